### rtl/core/b64sc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

   localparam logic       DIR_ENCODE = 1'b0;
   localparam logic       DIR_DECODE = 1'b1;
   localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='

   typedef struct packed {
      logic [7:0] in_byte;
      logic       message_end;
   } b64sc_item_type;

   // up to four result bytes, lowest index goes out first
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      count;
      logic            done;
   } b64sc_result_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } b64sc_sextet_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = {2'b00, v} + 8'h41;
      end else if (v < 6'd52) begin
         c = {2'b00, v} + 8'h47;            // 'a' - 26
      end else if (v < 6'd62) begin
         c = {2'b00, v} - 8'h04;            // '0' - 52
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   function automatic b64sc_sextet_type dec_char(input logic [7:0] c);
      b64sc_sextet_type s;
      s.valid = 1'b1;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         s.value = 6'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         s.value = 6'(c + 8'h04);
      end else if (c == 8'h2B) begin
         s.value = 6'd62;
      end else if (c == 8'h2F) begin
         s.value = 6'd63;
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

### rtl/core/b64sc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_if
// Valid/ready channel interfaces for the codec's request and response sides.
// ----------------------------------------------------------------------------
interface b64sc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       message_end;

   modport source (output valid, output in_byte, output message_end, input ready);
   modport sink   (input valid, input in_byte, input message_end, output ready);
endinterface

interface b64sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       message_done;

   modport source (output valid, output out_byte, output run_last, output message_done,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input message_done,
                   output ready);
endinterface
`default_nettype wire

### rtl/core/base64_stream_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder/decoder, direction chosen by a one-bit register.
// ----------------------------------------------------------------------------
//   channel   direction   handshake         payload
//   req       in          valid / ready     in_byte, message_end
//   rsp       out         valid / ready     out_byte, run_last, message_done
//   csr       in          csr_wr_en         csr_wr_data (direction)
//
// An item waits in the input register until taken; its zero to four results
// are computed in one pass and loaded into the result register. The single
// result port sets the rate: results leave one at a time. The next item loads
// as the last result of the one before leaves, so a response stall holds
// req.ready low. Synchronous reset clears the control and group state, but not
// the data registers.
// ----------------------------------------------------------------------------
module base64_stream_codec (
   input  wire logic  clock,
   input  wire logic  reset,
   b64sc_req_if.sink  req,
   b64sc_rsp_if.source rsp,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data
);
   import b64sc_pkg::*;

   b64sc_item_type   req_item;
   b64sc_item_type   item;
   b64sc_result_type result;
   logic             item_valid;
   logic             free;
   logic             take;

   assign req_item.in_byte     = req.in_byte;
   assign req_item.message_end = req.message_end;
   assign take                 = item_valid && free;

   b64sc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   b64sc_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .item        (item),
      .result      (result)
   );

   b64sc_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (take),
      .result           (result),
      .free             (free),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_out_byte     (rsp.out_byte),
      .rsp_run_last     (rsp.run_last),
      .rsp_message_done (rsp.message_done)
   );

endmodule
`default_nettype wire

### rtl/core/b64sc_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_in_stage
// Input register: holds one accepted item until the engine takes it.
// ----------------------------------------------------------------------------
module b64sc_in_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire b64sc_pkg::b64sc_item_type req_item,
   input  wire logic                    take,
   output logic                         item_valid,
   output b64sc_pkg::b64sc_item_type    item
);
   import b64sc_pkg::*;

   logic           valid_ff, valid_in;
   b64sc_item_type item_ff;

   assign req_ready  = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule
`default_nettype wire

### rtl/core/b64sc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_engine
// Group state, direction register and the per-item encode/decode logic.
// ----------------------------------------------------------------------------
module b64sc_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_wr_data,
   input  wire logic                      take,
   input  wire b64sc_pkg::b64sc_item_type item,
   output b64sc_pkg::b64sc_result_type    result
);
   import b64sc_pkg::*;

   logic             dir_ff;
   logic [17:0]      held_ff, held_in;
   logic [1:0]       fill_ff, fill_in;
   logic             stopped_ff, stopped_in;
   logic [7:0]       b;
   b64sc_sextet_type sx;

   assign b  = item.in_byte;
   assign sx = dec_char(item.in_byte);

   always_comb begin
      held_in     = held_ff;
      fill_in     = fill_ff;
      stopped_in  = stopped_ff;
      result      = '0;
      result.done = item.message_end;
      if (dir_ff == DIR_ENCODE) begin
         if (fill_ff == 2'd2) begin
            result.data[0] = enc_char(held_ff[15:10]);
            result.data[1] = enc_char({held_ff[9:8], held_ff[7:4]});
            result.data[2] = enc_char({held_ff[3:0], b[7:6]});
            result.data[3] = enc_char(b[5:0]);
            result.count   = 3'd4;
            held_in        = '0;
            fill_in        = 2'd0;
         end else begin
            held_in = {held_ff[9:0], b};
            fill_in = fill_ff + 2'd1;
            if (item.message_end) begin
               result.count   = 3'd4;
               result.data[3] = PAD_CHAR;
               if (fill_ff == 2'd0) begin
                  result.data[0] = enc_char(b[7:2]);
                  result.data[1] = enc_char({b[1:0], 4'b0000});
                  result.data[2] = PAD_CHAR;
               end else begin
                  result.data[0] = enc_char(held_ff[7:2]);
                  result.data[1] = enc_char({held_ff[1:0], b[7:4]});
                  result.data[2] = enc_char({b[3:0], 2'b00});
               end
            end
         end
      end else begin
         if (stopped_ff || !sx.valid) begin
            stopped_in = 1'b1;
         end else if (fill_ff == 2'd3) begin
            result.data[0] = held_ff[17:10];
            result.data[1] = {held_ff[9:2]};
            result.data[2] = {held_ff[1:0], sx.value};
            result.count   = 3'd3;
            held_in        = '0;
            fill_in        = 2'd0;
         end else begin
            held_in = {held_ff[11:0], sx.value};
            fill_in = fill_ff + 2'd1;
         end
         // tail of a partial group at message end
         if (item.message_end) begin
            case (fill_in)
               2'd2: begin
                  result.data[0] = held_in[11:4];
                  result.count   = 3'd1;
               end
               2'd3: begin
                  result.data[0] = held_in[17:10];
                  result.data[1] = held_in[9:2];
                  result.count   = 3'd2;
               end
               default: begin
               end
            endcase
         end
      end
      if (item.message_end) begin
         held_in    = '0;
         fill_in    = 2'd0;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= DIR_ENCODE;
         held_ff    <= '0;
         fill_ff    <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (csr_wr_en) begin
         dir_ff     <= csr_wr_data;
         held_ff    <= '0;
         fill_ff    <= 2'd0;
         stopped_ff <= 1'b0;
      end else if (take) begin
         held_ff    <= held_in;
         fill_ff    <= fill_in;
         stopped_ff <= stopped_in;
      end
   end

   a_msg_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && item.message_end |=> fill_ff == 2'd0 && !stopped_ff)
      else $error("group state not cleared after message end");

   a_enc_fill_range: assert property (@(posedge clock) disable iff (reset)
      dir_ff == DIR_ENCODE |-> fill_ff != 2'd3)
      else $error("encoder group holds more than two bytes");

endmodule
`default_nettype wire

### rtl/core/b64sc_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_out_buf
// Result register: holds the results of one item and shifts them out in order.
// ----------------------------------------------------------------------------
module b64sc_out_buf (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire b64sc_pkg::b64sc_result_type result,
   output logic                             free,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_run_last,
   output logic                             rsp_message_done
);
   import b64sc_pkg::*;

   logic [3:0][7:0] data_ff, data_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            done_ff;
   logic            xfer;

   assign rsp_valid        = cnt_ff != 3'd0;
   assign xfer             = rsp_valid && rsp_ready;
   assign free             = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_ready);
   assign rsp_out_byte     = data_ff[0];
   assign rsp_run_last     = cnt_ff == 3'd1;
   assign rsp_message_done = cnt_ff == 3'd1 && done_ff;

   always_comb begin
      data_in = data_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         data_in = result.data;
         cnt_in  = result.count;
      end else if (xfer) begin
         data_in = {8'h00, data_ff[3:1]};
         cnt_in  = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (load) begin
            done_ff <= result.done;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result count out of range");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register overwritten before drained");

endmodule
`default_nettype wire

### dv/b64sc_tb_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_tb_pkg
// Alphabet table and result record shared by the codec testbench and checker.
// ----------------------------------------------------------------------------
package b64sc_tb_pkg;

   // index 0 sits in the top byte, so B64_ALPHABET[v] is the character for v
   localparam logic [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       message_done;
   } codec_result_type;

endpackage

### dv/b64sc_checker.sv
// ----------------------------------------------------------------------------
// b64sc_checker
// Watches the request, response and register ports of the codec, keeps its
// own image of the group state, and compares every response transfer with
// the oldest predicted output byte.
// ----------------------------------------------------------------------------
module b64sc_checker (
   input  wire logic clock,
   input  wire logic reset,
   b64sc_req_if      req,
   b64sc_rsp_if      rsp,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data,
   output int        due_count,
   output int        mismatch_count
);
   import b64sc_pkg::*;
   import b64sc_tb_pkg::*;

   logic             dir;
   logic [17:0]      held;
   logic [1:0]       fill;
   logic             stopped;
   codec_result_type due_outputs[$];
   int               errors = 0;

   assign mismatch_count = errors;

   // {valid, sextet}
   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
         if (B64_ALPHABET[i] == c) return {1'b1, 6'(i)};
      end
      return 7'd0;
   endfunction

   function automatic codec_result_type plain_byte(input logic [7:0] v);
      return '{v, 1'b0, 1'b0};
   endfunction

   task automatic clear_group();
      held    = '0;
      fill    = '0;
      stopped = 1'b0;
   endtask

   task automatic translate_item(input logic [7:0] b, input logic e);
      logic [23:0]      word;
      logic [23:0]      full;
      logic [6:0]       sx;
      codec_result_type batch [0:3];
      int               n;
      n = 0;
      if (dir == DIR_ENCODE) begin
         word = {held[15:0], b};
         if (fill == 2'd2) begin
            for (int k = 0; k < 4; k++) begin
               batch[n] = plain_byte(B64_ALPHABET[word[23-6*k -: 6]]);
               n = n + 1;
            end
            held = '0;
            fill = '0;
         end else begin
            held = word[17:0];
            fill = fill + 2'd1;
            if (e) begin
               // zero-fill the short group up to 24 bits
               full = word << (8 * (3 - fill));
               for (int k = 0; k < 4; k++) begin
                  if (k <= fill) batch[n] = plain_byte(B64_ALPHABET[full[23-6*k -: 6]]);
                  else batch[n] = plain_byte(PAD_CHAR);
                  n = n + 1;
               end
            end
         end
      end else begin
         sx = char_sextet(b);
         if (stopped || !sx[6]) begin
            stopped = 1'b1;
         end else begin
            word = {held, sx[5:0]};
            if (fill == 2'd3) begin
               batch[0] = plain_byte(word[23:16]);
               batch[1] = plain_byte(word[15:8]);
               batch[2] = plain_byte(word[7:0]);
               n = 3;
               held = '0;
               fill = '0;
            end else begin
               held = word[17:0];
               fill = fill + 2'd1;
            end
         end
         // short group at message end: n characters give n-1 bytes
         if (e && fill >= 2'd2) begin
            full = 24'(held) << (6 * (4 - fill));
            for (int k = 0; k + 1 < fill; k++) begin
               batch[n] = plain_byte(full[23-8*k -: 8]);
               n = n + 1;
            end
         end
      end
      if (n > 0) begin
         batch[n-1].run_last = 1'b1;
         if (e) batch[n-1].message_done = 1'b1;
      end
      for (int k = 0; k < n; k++) due_outputs = {due_outputs, batch[k]};
      if (e) clear_group();
   endtask

   task automatic compare_output(input codec_result_type got);
      codec_result_type want;
      if (due_outputs.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("response transfer with nothing due: byte %02h run_last %0b done %0b",
                     got.out_byte, got.run_last, got.message_done);
      end else begin
         want = due_outputs.pop_front();
         if (want !== got) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                        want.out_byte, want.run_last, want.message_done,
                        got.out_byte, got.run_last, got.message_done);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dir = DIR_ENCODE;
         clear_group();
         due_outputs.delete();
      end else begin
         if (csr_wr_en) begin
            dir = csr_wr_data;
            clear_group();
         end
         // a response at this edge always belongs to an earlier request
         if (rsp.valid && rsp.ready)
            compare_output('{rsp.out_byte, rsp.run_last, rsp.message_done});
         if (req.valid && req.ready)
            translate_item(req.in_byte, req.message_end);
      end
      due_count <= due_outputs.size();
   end

endmodule

### dv/tb_base64_stream_codec.sv
// ----------------------------------------------------------------------------
// tb_base64_stream_codec
// Drives the codec with directed messages in both directions, then with
// random messages over several direction settings, under mostly bursty requests and
// a patterned response stall. The checker predicts and compares; this module
// makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_base64_stream_codec;
   import b64sc_pkg::*;
   import b64sc_tb_pkg::*;

   localparam int             SETTLE_CYCLES = 8;
   localparam int             PHASE_ITEMS   = 70;
   localparam logic [0:5]     PHASE_DIR     = 6'b011010;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_byte = 8'h00;
   logic        req_end = 1'b0;
   logic        rsp_take = 1'b0;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic [15:0] stall_mask = 16'hFFFF;
   logic [5:0]  stall_phase = 6'd0;
   logic        cur_dir = DIR_ENCODE;
   int          due_count;
   int          mismatches;
   int          sent = 0;
   int          burst_left = 0;
   bit          steady_send = 1'b0;

   b64sc_req_if req_bus ();
   b64sc_rsp_if rsp_bus ();

   assign req_bus.valid       = req_valid;
   assign req_bus.in_byte     = req_byte;
   assign req_bus.message_end = req_end;
   assign rsp_bus.ready       = rsp_take;

   base64_stream_codec dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   b64sc_checker codec_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .due_count      (due_count),
      .mismatch_count (mismatches)
   );

   always #1 clock = ~clock;

   // receiver: a fresh 16-bit ready pattern at each wrap of the phase counter, never all stalls
   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == 6'd63) begin
         case ($urandom_range(0, 3))
            0: stall_mask <= 16'hFFFF;
            1: stall_mask <= 16'h0101;
            default: stall_mask <= 16'($urandom) | 16'h0001;
         endcase
      end
      rsp_take <= stall_mask[stall_phase[3:0]];
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   // one request transfer; gaps fall between bursts unless sending steadily
   task automatic push_item(input logic [7:0] b, input logic e);
      int gap;
      if (!steady_send && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte  <= b;
      req_end   <= e;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
      if (burst_left > 0) burst_left--;
   endtask

   // hold off until every predicted byte is out and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_direction(input logic d);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      cur_dir = d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_chars(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) push_item(s[i], close && (i == s.len() - 1));
   endtask

   task automatic send_bytes(input int n);
      for (int i = 0; i < n; i++) push_item(8'($urandom), i == n - 1);
   endtask

   // mostly clean base64 text, sometimes padded; noisy text has stray bytes
   task automatic send_text(input int n, input bit noisy);
      logic [7:0] text[$];
      for (int i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 3) == 0) text = {text, 8'($urandom)};
         else text = {text, B64_ALPHABET[$urandom_range(0, 63)]};
      end
      if ((n % 4) != 0 && $urandom_range(0, 1) == 1) begin
         repeat (4 - n % 4) text = {text, PAD_CHAR};
         if (noisy) text = {text, B64_ALPHABET[$urandom_range(0, 63)]};
      end
      for (int i = 0; i < text.size(); i++) push_item(text[i], i == text.size() - 1);
   endtask

   initial begin
      int  start;
      int  n;
      bit  paused;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // encode: one to four bytes, all-zero and all-one patterns
      write_direction(DIR_ENCODE);
      push_item(8'h4D, 1'b1);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b1);
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'hA5, 1'b1);
      push_item(8'h5A, 1'b0);
      push_item(8'h3C, 1'b0);
      push_item(8'hC3, 1'b0);
      push_item(8'h01, 1'b1);
      // unfinished group, dropped by the direction write
      push_item(8'h12, 1'b0);
      push_item(8'h34, 1'b0);

      write_direction(DIR_DECODE);
      send_chars("TWFu", 1'b1);
      send_chars("TQ", 1'b1);
      send_chars("A", 1'b1);          // one character: nothing comes out
      send_chars("/+9=", 1'b1);       // pad stops decoding
      send_chars("za", 1'b0);
      push_item(8'hFF, 1'b0);         // non-alphabet stop
      push_item(8'h51, 1'b1);         // ignored after the stop

      for (int ph = 0; ph < 6; ph++) begin
         write_direction(PHASE_DIR[ph]);
         steady_send = (ph == 3);
         start = sent;
         while (sent - start < PHASE_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (cur_dir == DIR_ENCODE) send_bytes(n);
            else send_text(n, $urandom_range(0, 4) == 0);
            if (ph == 2 && !paused && sent - start > PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
         end
         if (ph % 2 == 0) begin
            repeat ($urandom_range(1, 3))
               push_item(cur_dir == DIR_ENCODE ? 8'($urandom)
                                               : B64_ALPHABET[$urandom_range(0, 63)], 1'b0);
         end
      end
      steady_send = 1'b0;

      drain();
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

### base64_stream_codec.f
rtl/core/b64sc_pkg.sv
rtl/core/b64sc_if.sv
rtl/core/b64sc_in_stage.sv
rtl/core/b64sc_engine.sv
rtl/core/b64sc_out_buf.sv
rtl/core/base64_stream_codec.sv
dv/b64sc_tb_pkg.sv
dv/b64sc_checker.sv
dv/tb_base64_stream_codec.sv
